// ----- rtl/core/pixel_to_ascii_glyph_and_palette_defines.svh -----
// Assertion macros used by the checker file of the glyph and palette block.
`ifndef PIXEL_TO_ASCII_GLYPH_AND_PALETTE_DEFINES_SVH
`define PIXEL_TO_ASCII_GLYPH_AND_PALETTE_DEFINES_SVH

// Implication checked every clock, held off during reset.
`define P2A_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("p2a check failed");

// Condition that must hold at every clock outside reset.
`define P2A_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("p2a check failed");

`endif

// ----- rtl/core/p2a_pkg.sv -----
// Shared types, constant tables and a helper function of the glyph and palette block.
package p2a_pkg;

	localparam int NUM_COLORS = 16;
	localparam int NUM_CHANS  = 3;
	localparam int NUM_LEVELS = 4;
	localparam int RAMP_LEN   = 10;
	localparam int RAMP_TOP   = 9;

	typedef logic [7:0]  chan_t;
	typedef logic [15:0] sq_t;
	typedef logic [17:0] dist_t;
	typedef logic [3:0]  cidx_t;
	typedef logic [6:0]  glyph_t;

	// luma weights and divide-by-100 reciprocal (exact for sums below 43690)
	localparam int LUMA_WR      = 30;
	localparam int LUMA_WG      = 59;
	localparam int LUMA_WB      = 11;
	localparam int RECIP_DIV100 = 5243;
	localparam int RECIP_SHIFT  = 19;
	localparam int LUMA_FULL    = 255;

	// every CGA channel takes one of these four values
	localparam chan_t CH_LEVEL [NUM_LEVELS] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

	localparam logic [23:0] CGA_TABLE [NUM_COLORS] = '{
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
	};

	localparam glyph_t RAMP [RAMP_LEN] = '{
		7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40
	};

	// channel value of a palette entry -> index into CH_LEVEL
	function automatic logic [1:0] level_code(input chan_t c);
		logic [1:0] code;
		code = 2'd3;
		for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
			if (c == CH_LEVEL[k]) begin
				code = 2'(k);
			end
		end
		return code;
	endfunction

endpackage

// ----- rtl/core/p2a_luma.sv -----
// Luma path: weighted sum, divide by 100, ramp level, glyph lookup (five stages).
module p2a_luma
	import p2a_pkg::*;
(
	input  logic         clk,
	input  logic [15:0]  pixel,
	output glyph_t       glyph
);

	chan_t        r, g, b;
	logic [14:0]  sum_s1;
	logic [27:0]  prod;
	chan_t        lum_s2;
	logic [3:0]   lvl;
	logic [3:0]   level_s3;
	glyph_t       glyph_s4;
	glyph_t       glyph_s5;

	assign r = {pixel[15:11], 3'b000};
	assign g = {pixel[10:5], 2'b00};
	assign b = {pixel[4:0], 3'b000};

	assign prod = 28'(sum_s1) * 28'(RECIP_DIV100);

	// level = lum*9/255 as a count of crossed thresholds
	always_comb begin
		lvl = 4'd0;
		for (int k = 1; k <= RAMP_TOP; k++) begin
			if ({4'b0000, lum_s2} * 12'(RAMP_TOP) >= 12'(LUMA_FULL * k)) begin
				lvl = lvl + 4'd1;
			end
		end
		if (lvl > 4'(RAMP_TOP)) begin
			lvl = 4'(RAMP_TOP);
		end
	end

	always_ff @(posedge clk) begin
		sum_s1   <= 15'(15'(r) * 15'(LUMA_WR) + 15'(g) * 15'(LUMA_WG) + 15'(b) * 15'(LUMA_WB));
		lum_s2   <= 8'(prod >> RECIP_SHIFT);
		level_s3 <= lvl;
		glyph_s4 <= RAMP[level_s3];
		glyph_s5 <= glyph_s4;
	end

	assign glyph = glyph_s5;

endmodule

// ----- rtl/core/p2a_dist.sv -----
// Palette distance path: channel differences, squares, per-entry sums (three stages).
module p2a_dist
	import p2a_pkg::*;
(
	input  logic         clk,
	input  logic [15:0]  pixel,
	output dist_t        dists [NUM_COLORS]
);

	chan_t chan [NUM_CHANS];
	chan_t adiff_s1 [NUM_CHANS][NUM_LEVELS];
	sq_t   sq_s2 [NUM_CHANS][NUM_LEVELS];
	dist_t dist_s3 [NUM_COLORS];

	assign chan[0] = {pixel[15:11], 3'b000};
	assign chan[1] = {pixel[10:5], 2'b00};
	assign chan[2] = {pixel[4:0], 3'b000};

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CHANS; c++) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				adiff_s1[c][l] <= (chan[c] >= CH_LEVEL[l]) ? chan[c] - CH_LEVEL[l]
				                                          : CH_LEVEL[l] - chan[c];
				sq_s2[c][l]    <= 16'(adiff_s1[c][l]) * 16'(adiff_s1[c][l]);
			end
		end
		for (int i = 0; i < NUM_COLORS; i++) begin
			dist_s3[i] <= 18'(sq_s2[0][level_code(CGA_TABLE[i][23:16])])
			            + 18'(sq_s2[1][level_code(CGA_TABLE[i][15:8])])
			            + 18'(sq_s2[2][level_code(CGA_TABLE[i][7:0])]);
		end
	end

	assign dists = dist_s3;

endmodule

// ----- rtl/core/p2a_argmin.sv -----
// Registered minimum tree over the 16 palette distances, lowest index on ties.
module p2a_argmin
	import p2a_pkg::*;
(
	input  logic   clk,
	input  dist_t  dists [NUM_COLORS],
	output cidx_t  color_index
);

	localparam int GROUPS = NUM_COLORS / 4;

	typedef struct packed {
		dist_t d;
		cidx_t idx;
	} cand_t;

	cand_t leaf [NUM_COLORS];
	cand_t cand_s4 [GROUPS];
	cand_t best_s5;

	// a holds the lower index; b wins only when strictly nearer
	function automatic cand_t pick(input cand_t a, input cand_t b);
		return (b.d < a.d) ? b : a;
	endfunction

	function automatic cand_t best4(input cand_t a, input cand_t b,
	                                input cand_t c, input cand_t d);
		return pick(pick(a, b), pick(c, d));
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_COLORS; i++) begin
			leaf[i].d   = dists[i];
			leaf[i].idx = cidx_t'(i);
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < GROUPS; g++) begin
			cand_s4[g] <= best4(leaf[4*g], leaf[4*g+1], leaf[4*g+2], leaf[4*g+3]);
		end
		best_s5 <= best4(cand_s4[0], cand_s4[1], cand_s4[2], cand_s4[3]);
	end

	assign color_index = best_s5.idx;

endmodule

// ----- rtl/core/pixel_to_ascii_glyph_and_palette.sv -----
// Top level: RGB565 pixel to ASCII ramp glyph and nearest CGA palette index.
// Pipeline: a pixel taken with start passes the stage registers of both datapaths and
//   shows on glyph/color_index together with done.
// Throughput: one pixel per clock; busy is never raised, the pipeline has no stall.
// Reset (arst_n low, asynchronous): clears the stage valid bits, so done stays low
//   until a fresh transfer; data registers are not reset. The receiver cannot stall.
module pixel_to_ascii_glyph_and_palette
	import p2a_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [15:0]  pixel,
	output logic         done,
	output logic [6:0]   glyph,
	output logic [3:0]   color_index
);

	localparam int DEPTH = 5;

	logic        take;
	logic [DEPTH-1:0] valid_q;  // bit k: stage k+1 holds a live pixel
	dist_t       dists [NUM_COLORS];
	glyph_t      glyph_w;
	cidx_t       cidx_w;

	// Every stage advances on every clock, so the block is always free.
	assign busy = 1'b0;
	assign take = start && !busy;

	// Valid bits ride alongside the data stages in the two datapaths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[DEPTH-2:0], take};
		end
	end

	// Luma path: stages 1-5 (sum, /100 by reciprocal, level, lookup, align).
	p2a_luma u_luma (
		.clk   (clk),
		.pixel (pixel),
		.glyph (glyph_w)
	);

	// Distance path: stages 1-3 (abs diffs, squares, per-entry sums).
	p2a_dist u_dist (
		.clk   (clk),
		.pixel (pixel),
		.dists (dists)
	);

	// Minimum search: stages 4-5 (groups of four, then final four).
	p2a_argmin u_argmin (
		.clk         (clk),
		.dists       (dists),
		.color_index (cidx_w)
	);

	assign done        = valid_q[DEPTH-1];
	assign glyph       = glyph_w;
	assign color_index = cidx_w;

endmodule

// ----- rtl/core/p2a_checker.sv -----
// Port-level checker for the glyph and palette block, bound to the top level.
`include "pixel_to_ascii_glyph_and_palette_defines.svh"

module p2a_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] pixel,
	input logic        done,
	input logic [6:0]  glyph,
	input logic [3:0]  color_index
);

	`P2A_ASSERT_ALWAYS(a_never_busy, !busy)
	`P2A_ASSERT_IMP(a_start_gives_done, start && !busy, ##5 done)
	`P2A_ASSERT_IMP(a_done_has_cause, done, $past(start && !busy, 5))
	`P2A_ASSERT_IMP(a_black_pixel, start && !busy && pixel == 16'h0000, ##5 (glyph == 7'h20 && color_index == 4'd0))
	`P2A_ASSERT_IMP(a_no_top_glyph, done, glyph != 7'h40)

endmodule

bind pixel_to_ascii_glyph_and_palette p2a_checker u_p2a_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.pixel       (pixel),
	.done        (done),
	.glyph       (glyph),
	.color_index (color_index)
);
